[src/leg_pkg.sv]
// Shared types, register and mode codes, and the raised-cosine wave table.
`default_nettype none
package leg_pkg;

    localparam int WAVE_N     = 256;
    localparam int WAVE_IDX_W = 8;
    localparam int WAVE_W     = 17;
    localparam int MUL_A_W    = 24;
    localparam int MUL_B_W    = 8;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W    = 24;
    localparam int DIV_D_W    = 16;
    localparam int FT_W       = 5;

    localparam logic [WAVE_IDX_W-1:0] WAVE_QUARTER = WAVE_IDX_W'(WAVE_N / 4);

    localparam logic [2:0] CFG_EFFECT_MODE  = 3'd0;
    localparam logic [2:0] CFG_BASE_COLOR   = 3'd1;
    localparam logic [2:0] CFG_MIN_LEVEL    = 3'd2;
    localparam logic [2:0] CFG_MAX_LEVEL    = 3'd3;
    localparam logic [2:0] CFG_BREATH_PER   = 3'd4;
    localparam logic [2:0] CFG_PULSE_LEN    = 3'd5;
    localparam logic [2:0] CFG_BRIGHTNESS   = 3'd6;

    localparam logic [2:0] MODE_OFF     = 3'd0;
    localparam logic [2:0] MODE_STATIC  = 3'd1;
    localparam logic [2:0] MODE_RAINBOW = 3'd2;
    localparam logic [2:0] MODE_BREATH  = 3'd3;
    localparam logic [2:0] MODE_PULSE   = 3'd4;

    localparam logic [15:0] BREATH_MIN_MS = 16'd800;
    localparam logic [8:0]  HUE_LAST      = 9'd359;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] mcand;
        logic [MUL_B_W-1:0] mplier;
    } t_mul_req;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } t_div_req;

    typedef logic [WAVE_N-1:0][WAVE_W-1:0] t_wave_tab;

    // Entry k holds sin^2(pi*k/N) in Q1.16, from an integer Taylor series in Q30.
    // The series terms divide by the fixed factors 2*3, 4*5, 6*7, 8*9 and 10*11.
    function automatic t_wave_tab build_wave();
        t_wave_tab       tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned s;
        longint unsigned w;
        longint          acc;
        int              m;
        for (int k = 0; k < WAVE_N; k++) begin
            m    = (k > WAVE_N - k) ? (WAVE_N - k) : k;
            x    = (longint'(m) * 64'd3373259426) / WAVE_N;
            x2   = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            term = ((term * x2) >> 30) / 64'd6;
            acc  = acc - longint'(term);
            term = ((term * x2) >> 30) / 64'd20;
            acc  = acc + longint'(term);
            term = ((term * x2) >> 30) / 64'd42;
            acc  = acc - longint'(term);
            term = ((term * x2) >> 30) / 64'd72;
            acc  = acc + longint'(term);
            term = ((term * x2) >> 30) / 64'd110;
            acc  = acc - longint'(term);
            if (acc < 0) begin
                acc = 0;
            end
            if (acc > 64'sd1073741824) begin
                acc = 64'sd1073741824;
            end
            s = longint'(acc);
            w = (s * s + (64'd1 << 43)) >> 44;
            if (w > 64'd65536) begin
                w = 64'd65536;
            end
            tab[k] = w[WAVE_W-1:0];
        end
        return tab;
    endfunction

    localparam t_wave_tab WAVE_TAB = build_wave();

endpackage
`default_nettype wire

[src/leg_sermul.sv]
// Shift-and-add multiplier retiring one multiplier bit per cycle.
`default_nettype none
module leg_sermul import leg_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_mul_req           i_req,
    output logic                    o_done,
    output logic [MUL_P_W-1:0]      o_prod
);

    localparam int CNT_W = $clog2(MUL_B_W + 1);

    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [MUL_P_W-1:0] r_prod;
    logic [MUL_A_W-1:0] r_mcand;
    logic [MUL_A_W:0]   sum;

    assign sum = {1'b0, r_prod[MUL_P_W-1:MUL_B_W]}
               + (r_prod[0] ? {1'b0, r_mcand} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_cnt  <= CNT_W'(MUL_B_W);
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_prod  <= {{MUL_A_W{1'b0}}, i_req.mplier};
            r_mcand <= i_req.mcand;
        end else if (r_busy) begin
            r_prod <= {sum, r_prod[MUL_B_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule
`default_nettype wire

[src/leg_serdiv.sv]
// Restoring divider producing one quotient bit per cycle.
`default_nettype none
module leg_serdiv import leg_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_div_req           i_req,
    output logic                    o_done,
    output logic [DIV_N_W-1:0]      o_quo
);

    localparam int CNT_W = $clog2(DIV_N_W + 1);

    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_N_W-1:0] r_quo;
    logic [DIV_D_W-1:0] r_dvs;
    logic [DIV_D_W+1:0] diff;
    logic               ge;

    assign diff = {1'b0, r_rem, r_quo[DIV_N_W-1]} - {2'b00, r_dvs};
    assign ge   = !diff[DIV_D_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_cnt  <= CNT_W'(DIV_N_W);
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIV_D_W-1:0] : {r_rem[DIV_D_W-2:0], r_quo[DIV_N_W-1]};
            r_quo <= {r_quo[DIV_N_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
`default_nettype wire

[src/led_effect_generator.sv]
// Top level of the LED effect generator: tick sequencer, effect state and output register.
//
//  channel   direction  handshake              payload
//  tick      in         i_valid / o_ready      i_restart
//  frame     out        o_valid / i_ready      o_red, o_green, o_blue, o_effect_running
//  config    in         i_cfg_we               i_cfg_addr, i_cfg_wdata
//
// A tick is taken only while the sequencer is idle. Off, static, rainbow and a pulse
// between samples need three serial scaling multiplies plus the control states.
// Breathing adds the divider pass, one level multiply and three colour multiplies; a
// pulse sample takes the same path without the level multiply. The tick time is
// set by the single shift-and-add multiplier and the bit-serial divider, which are shared.
// Reset is synchronous and active low; it loads the register defaults and clears all
// effect state. A finished frame waits in the output register; when that register is
// still full as the next frame completes, the sequencer holds until it is taken.
`default_nettype none
module led_effect_generator import leg_pkg::*; #(
    parameter int RAINBOW_FRAME_MS = 30,
    parameter int PULSE_FRAME_MS   = 20
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // tick requests
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_restart,
    // frame results
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic             o_effect_running,
    // register writes
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [23:0] i_cfg_wdata
);

    // Frame lengths widened by one bit so that the incremented counter compares cleanly.
    localparam logic [FT_W:0] RAIN_LEN  = (FT_W + 1)'(RAINBOW_FRAME_MS);
    localparam logic [FT_W:0] PULSE_LEN = (FT_W + 1)'(PULSE_FRAME_MS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_LVL   = 6'b000100,
        S_CHAN  = 6'b001000,
        S_SCALE = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    // Configuration registers.
    logic [2:0]  r_mode;
    logic [23:0] r_base;
    logic [7:0]  r_min;
    logic [7:0]  r_max;
    logic [15:0] r_per;
    logic [15:0] r_plen;
    logic [8:0]  r_bs;

    // Effect state carried from tick to tick.
    logic [15:0]     r_time, n_time;
    logic [8:0]      r_hue,  n_hue;
    logic [FT_W-1:0] r_ft,   n_ft;
    logic            r_pf,   n_pf;
    logic [23:0]     r_held, n_held;

    // Sequencer.
    t_state          r_state, n_state;
    logic            r_breath, n_breath;
    logic [1:0]      r_ch, n_ch;
    logic [23:0]     r_color, n_color;
    logic            r_run, n_run;
    logic [WAVE_W-1:0] r_w, n_w;
    logic [23:0]     r_lvl, n_lvl;

    // Output register.
    logic        r_o_valid, n_o_valid;
    logic [23:0] r_o_rgb, n_o_rgb;
    logic        r_o_run, n_o_run;

    // Shared serial units.
    t_mul_req           mul_req;
    t_div_req           div_req;
    logic               mul_done;
    logic               div_done;
    logic [MUL_P_W-1:0] mul_prod;
    logic [DIV_N_W-1:0] div_quo;

    // Per-tick decode of the effect, valid in the idle state.
    logic [15:0]     t0;
    logic [8:0]      h0;
    logic [FT_W-1:0] ft0;
    logic            pf0;
    logic [FT_W-1:0] ftc;
    logic [FT_W:0]   ft_inc;
    logic [7:0]      lvl_lo;
    logic [7:0]      lvl_span;
    logic [15:0]     per_eff;
    logic [15:0]     len_eff;
    logic [15:0]     acc_time;
    logic [8:0]      acc_hue;
    logic [FT_W-1:0] acc_ft;
    logic            acc_pf;
    logic [23:0]     acc_held;
    logic [23:0]     acc_color;
    logic            acc_run;
    logic            acc_breath;
    logic            acc_pulse;

    // Datapath helpers between the units and the colour register.
    logic [WAVE_IDX_W-1:0] wave_idx;
    logic [WAVE_W-1:0]     wave_val;
    logic [23:0]           lvl_sum;
    logic [16:0]           d255;
    logic [7:0]            chan_res;
    logic [17:0]           sc_round;
    logic [7:0]            sc_res;
    logic                  accept;

    // Six-region colour wheel; the remainder scale 255/60 is exactly 17/4.
    function automatic logic [23:0] wheel(input logic [8:0] hue);
        logic [2:0] region;
        logic [8:0] rem;
        logic [9:0] rem17;
        logic [7:0] r;
        if (hue < 9'd60) begin
            region = 3'd0; rem = hue;
        end else if (hue < 9'd120) begin
            region = 3'd1; rem = hue - 9'd60;
        end else if (hue < 9'd180) begin
            region = 3'd2; rem = hue - 9'd120;
        end else if (hue < 9'd240) begin
            region = 3'd3; rem = hue - 9'd180;
        end else if (hue < 9'd300) begin
            region = 3'd4; rem = hue - 9'd240;
        end else begin
            region = 3'd5; rem = hue - 9'd300;
        end
        rem17 = {rem[5:0], 4'b0000} + {4'b0000, rem[5:0]};
        r     = rem17[9:2];
        unique case (region)
            3'd0:    return {8'hFF, r, 8'h00};
            3'd1:    return {8'hFF - r, 8'hFF, 8'h00};
            3'd2:    return {8'h00, 8'hFF, r};
            3'd3:    return {8'h00, 8'hFF - r, 8'hFF};
            3'd4:    return {r, 8'h00, 8'hFF};
            default: return {8'hFF, 8'h00, 8'hFF - r};
        endcase
    endfunction

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);

    // A restart clears effect time, hue, frame count and the pulse end before the frame.
    always_comb begin
        t0  = i_restart ? 16'd0 : r_time;
        h0  = i_restart ? 9'd0 : r_hue;
        ft0 = i_restart ? '0 : r_ft;
        pf0 = i_restart ? 1'b0 : r_pf;

        lvl_lo   = (r_max < r_min) ? r_max : r_min;
        lvl_span = (r_max < r_min) ? (r_min - r_max) : (r_max - r_min);
        per_eff  = (r_per < BREATH_MIN_MS) ? BREATH_MIN_MS : r_per;
        len_eff  = (r_plen == 16'd0) ? 16'd1 : r_plen;

        acc_hue    = h0;
        acc_ft     = '0;
        acc_pf     = pf0;
        acc_held   = r_held;
        acc_color  = 24'd0;
        acc_run    = 1'b0;
        acc_breath = 1'b0;
        acc_pulse  = 1'b0;
        ftc        = '0;
        ft_inc     = '0;

        unique case (r_mode)
            MODE_STATIC: begin
                acc_color = r_base;
                acc_run   = 1'b1;
            end
            MODE_RAINBOW: begin
                ftc = ({1'b0, ft0} >= RAIN_LEN) ? '0 : ft0;
                if (ftc == '0) begin
                    acc_held = wheel(h0);
                    acc_hue  = (h0 >= HUE_LAST) ? 9'd0 : h0 + 9'd1;
                end
                ft_inc    = {1'b0, ftc} + (FT_W + 1)'(1);
                acc_ft    = (ft_inc >= RAIN_LEN) ? '0 : ft_inc[FT_W-1:0];
                acc_color = acc_held;
                acc_run   = 1'b1;
            end
            MODE_BREATH: begin
                acc_breath = 1'b1;
                acc_run    = 1'b1;
            end
            MODE_PULSE: begin
                ftc = ({1'b0, ft0} >= PULSE_LEN) ? '0 : ft0;
                if (!pf0 && ftc == '0) begin
                    if (t0 >= len_eff) begin
                        acc_pf = 1'b1;
                    end else begin
                        acc_pulse = 1'b1;
                    end
                end
                ft_inc    = {1'b0, ftc} + (FT_W + 1)'(1);
                acc_ft    = (ft_inc >= PULSE_LEN) ? '0 : ft_inc[FT_W-1:0];
                acc_run   = !acc_pf;
                acc_color = acc_pf ? 24'd0 : r_held;
            end
            default: begin
                acc_color = 24'd0;
            end
        endcase

        // Pulse time stops at the top of its range; every other mode wraps.
        if (r_mode == MODE_PULSE && t0 == 16'hFFFF) begin
            acc_time = 16'hFFFF;
        end else begin
            acc_time = t0 + 16'd1;
        end
    end

    // Wave index: low byte of (time * N) / period, the phase in the period; a pulse adds N/4.
    assign wave_idx = r_breath ? div_quo[WAVE_IDX_W-1:0]
                               : div_quo[WAVE_IDX_W-1:0] + WAVE_QUARTER;
    assign wave_val = WAVE_TAB[wave_idx];
    assign lvl_sum  = {lvl_lo, 16'd0} + mul_prod[23:0];

    // Breathing divides c*L by 255*65536: drop 16 bits, then divide by 255 exactly.
    assign d255     = {1'b0, mul_prod[31:16]} + {9'd0, mul_prod[31:24]} + 17'd1;
    assign chan_res = r_breath ? d255[15:8] : mul_prod[23:16];

    // Global brightness: round half up, then saturate at full scale.
    assign sc_round = mul_prod[17:0] + 18'd128;
    assign sc_res   = (sc_round[17:16] != 2'b00) ? 8'hFF : sc_round[15:8];

    always_comb begin
        n_state   = r_state;
        n_breath  = r_breath;
        n_ch      = r_ch;
        n_color   = r_color;
        n_run     = r_run;
        n_w       = r_w;
        n_lvl     = r_lvl;
        n_time    = r_time;
        n_hue     = r_hue;
        n_ft      = r_ft;
        n_pf      = r_pf;
        n_held    = r_held;
        n_o_valid = r_o_valid && !i_ready;
        n_o_rgb   = r_o_rgb;
        n_o_run   = r_o_run;
        mul_req   = '0;
        div_req   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_time   = acc_time;
                    n_hue    = acc_hue;
                    n_ft     = acc_ft;
                    n_pf     = acc_pf;
                    n_held   = acc_held;
                    n_run    = acc_run;
                    n_breath = acc_breath;
                    n_ch     = 2'd0;
                    if (acc_breath || acc_pulse) begin
                        n_color          = r_base;
                        div_req.start    = 1'b1;
                        div_req.dividend = {t0, {WAVE_IDX_W{1'b0}}};
                        div_req.divisor  = acc_breath ? per_eff : len_eff;
                        n_state          = S_DIV;
                    end else begin
                        n_color        = acc_color;
                        mul_req.start  = 1'b1;
                        mul_req.mcand  = {15'd0, r_bs};
                        mul_req.mplier = acc_color[23:16];
                        n_state        = S_SCALE;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_w            = wave_val;
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = {7'd0, wave_val};
                    if (r_breath) begin
                        mul_req.mplier = lvl_span;
                        n_state        = S_LVL;
                    end else begin
                        mul_req.mplier = r_color[23:16];
                        n_state        = S_CHAN;
                    end
                end
            end
            S_LVL: begin
                if (mul_done) begin
                    n_lvl          = lvl_sum;
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = lvl_sum;
                    mul_req.mplier = r_color[23:16];
                    n_state        = S_CHAN;
                end
            end
            S_CHAN: begin
                // Each finished channel rotates in at the bottom, bringing the next to the top.
                if (mul_done) begin
                    n_color        = {r_color[15:0], chan_res};
                    mul_req.start  = 1'b1;
                    mul_req.mplier = r_color[15:8];
                    if (r_ch == 2'd2) begin
                        if (!r_breath) begin
                            n_held = {r_color[15:0], chan_res};
                        end
                        mul_req.mcand = {15'd0, r_bs};
                        n_ch          = 2'd0;
                        n_state       = S_SCALE;
                    end else begin
                        mul_req.mcand = r_breath ? r_lvl : {7'd0, r_w};
                        n_ch          = r_ch + 2'd1;
                    end
                end
            end
            S_SCALE: begin
                if (mul_done) begin
                    n_color = {r_color[15:0], sc_res};
                    if (r_ch == 2'd2) begin
                        n_state = S_DONE;
                    end else begin
                        mul_req.start  = 1'b1;
                        mul_req.mcand  = {15'd0, r_bs};
                        mul_req.mplier = r_color[15:8];
                        n_ch           = r_ch + 2'd1;
                    end
                end
            end
            S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_rgb   = r_color;
                    n_o_run   = r_run;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_OFF;
            r_base    <= 24'd0;
            r_min     <= 8'd24;
            r_max     <= 8'd255;
            r_per     <= 16'd7000;
            r_plen    <= 16'd400;
            r_bs      <= 9'd90;
            r_time    <= 16'd0;
            r_hue     <= 9'd0;
            r_ft      <= '0;
            r_pf      <= 1'b0;
            r_held    <= 24'd0;
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_EFFECT_MODE: r_mode <= i_cfg_wdata[2:0];
                    CFG_BASE_COLOR:  r_base <= i_cfg_wdata;
                    CFG_MIN_LEVEL:   r_min  <= i_cfg_wdata[7:0];
                    CFG_MAX_LEVEL:   r_max  <= i_cfg_wdata[7:0];
                    CFG_BREATH_PER:  r_per  <= i_cfg_wdata[15:0];
                    CFG_PULSE_LEN:   r_plen <= i_cfg_wdata[15:0];
                    CFG_BRIGHTNESS:  r_bs   <= i_cfg_wdata[8:0];
                    default: begin
                    end
                endcase
            end
            r_time    <= n_time;
            r_hue     <= n_hue;
            r_ft      <= n_ft;
            r_pf      <= n_pf;
            r_held    <= n_held;
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_breath <= n_breath;
        r_ch     <= n_ch;
        r_color  <= n_color;
        r_run    <= n_run;
        r_w      <= n_w;
        r_lvl    <= n_lvl;
        r_o_rgb  <= n_o_rgb;
        r_o_run  <= n_o_run;
    end

    leg_sermul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    leg_serdiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_valid          = r_o_valid;
    assign o_red            = r_o_rgb[23:16];
    assign o_green          = r_o_rgb[15:8];
    assign o_blue           = r_o_rgb[7:0];
    assign o_effect_running = r_o_run;

`ifndef SYNTH
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hue <= HUE_LAST)
        else $error("hue left the colour wheel");

    a_dark_when_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_run) |-> (r_o_rgb == 24'd0))
        else $error("frame not black while no effect runs");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("sequencer idle straight after taking a tick");

    a_frame_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_o_valid && !i_ready) |=> (r_state == S_DONE))
        else $error("frame dropped while output register full");
`endif

endmodule
`default_nettype wire
